>>> hw/rtl/kies_pkg.sv
package kies_pkg;

   localparam int MaxDetents = 8;
   localparam int TouchBits  = 22;
   localparam int TimeW      = 32;
   localparam int CountW     = 32;
   localparam int CfgW       = 22;
   localparam int CsrIdxW    = 3;
   localparam int LongW      = 16;
   localparam int SpdW       = 4;
   localparam int NumOther   = 6;
   localparam int DetCntW    = $clog2(MaxDetents + 1);

   typedef enum logic [3:0] {
      EvCw       = 4'd0,
      EvCcw      = 4'd1,
      EvEncShort = 4'd2,
      EvEncLong  = 4'd3,
      EvAuxShort = 4'd4,
      EvAuxLong  = 4'd5,
      EvDitDown  = 4'd6,
      EvDitUp    = 4'd7,
      EvDahDown  = 4'd8,
      EvDahUp    = 4'd9,
      EvTlDown   = 4'd10,
      EvTlUp     = 4'd11,
      EvTrDown   = 4'd12,
      EvTrUp     = 4'd13
   } ev_code_type;

   typedef enum logic [CsrIdxW-1:0] {
      CsrTlOn     = 3'd0,
      CsrTlOff    = 3'd1,
      CsrTrOn     = 3'd2,
      CsrTrOff    = 3'd3,
      CsrLongMs   = 3'd4,
      CsrSpd      = 3'd5,
      CsrMaxHold  = 3'd6
   } csr_idx_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic eval;
      logic emit_detent;
      logic emit_other;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic detent_pending;
      logic other_pending;
      logic rsp_free;
   } dp_sts_type;

endpackage

>>> hw/rtl/kies_ctrl.sv
module kies_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  kies_pkg::dp_sts_type sts,
   output kies_pkg::dp_cmd_type cmd
);
   import kies_pkg::*;

   typedef enum logic [1:0] {
      StIdle,
      StEval,
      StDetent,
      StOther
   } fsm_state_type;

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   // held off during reset so no transfer is taken while state is cleared
   assign req_stall = reset || (state_ff != StIdle);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = StEval;
            end
         end
         StEval: begin
            cmd.eval = 1'b1;
            state_in = StDetent;
         end
         StDetent: begin
            if (!sts.detent_pending) begin
               state_in = StOther;
            end else if (sts.rsp_free) begin
               cmd.emit_detent = 1'b1;
            end
         end
         StOther: begin
            if (!sts.other_pending) begin
               state_in = StIdle;
            end else if (sts.rsp_free) begin
               cmd.emit_other = 1'b1;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

endmodule

>>> hw/rtl/kies_dp.sv
module kies_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  kies_pkg::dp_cmd_type                cmd,
   output kies_pkg::dp_sts_type                sts,
   input  logic                                csr_write_enable,
   input  logic [kies_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [kies_pkg::CfgW-1:0]           csr_write_data,
   input  logic [kies_pkg::TimeW-1:0]          req_now_ms,
   input  logic signed [kies_pkg::CountW-1:0]  req_encoder_count,
   input  logic                                req_encoder_button_down,
   input  logic                                req_aux_button_down,
   input  logic                                req_paddle_left_down,
   input  logic                                req_paddle_right_down,
   input  logic [kies_pkg::TouchBits-1:0]      req_touch_left_reading,
   input  logic [kies_pkg::TouchBits-1:0]      req_touch_right_reading,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [3:0]                          rsp_event_code,
   output logic                                rsp_last_of_tick
);
   import kies_pkg::*;

   typedef struct packed {
      logic             held;
      logic [TimeW-1:0] start;
      logic             long_sent;
   } btn_st_type;

   typedef struct packed {
      btn_st_type  st;
      logic        hit;
      ev_code_type code;
   } btn_res_type;

   typedef struct packed {
      logic             active;
      logic [TimeW-1:0] since;
   } tch_st_type;

   typedef struct packed {
      tch_st_type  st;
      logic        hit;
      ev_code_type code;
   } tch_res_type;

   function automatic btn_res_type btn_eval(input logic down, input btn_st_type st,
                                            input logic [TimeW-1:0] now,
                                            input logic [LongW-1:0] lp,
                                            input ev_code_type sev, input ev_code_type lev);
      btn_res_type      r;
      logic [TimeW-1:0] elapsed;
      r       = '{st: st, hit: 1'b0, code: sev};
      elapsed = now - st.start;
      if (down && !st.held) begin
         r.st.held      = 1'b1;
         r.st.start     = now;
         r.st.long_sent = 1'b0;
      end else if (down && !st.long_sent) begin
         if (elapsed >= TimeW'(lp)) begin
            r.hit          = 1'b1;
            r.code         = lev;
            r.st.long_sent = 1'b1;
         end
      end else if (!down && st.held) begin
         r.hit     = !st.long_sent;
         r.st.held = 1'b0;
      end
      return r;
   endfunction

   function automatic tch_res_type touch_eval(input logic [TouchBits-1:0] reading,
                                              input logic [CfgW-1:0] on_th,
                                              input logic [CfgW-1:0] off_th,
                                              input tch_st_type st,
                                              input logic [TimeW-1:0] now,
                                              input logic [LongW-1:0] max_hold,
                                              input ev_code_type dev, input ev_code_type uev);
      tch_res_type      r;
      logic             t;
      logic [TimeW-1:0] elapsed;
      r       = '{st: st, hit: 1'b0, code: uev};
      elapsed = now - st.since;
      t       = st.active ? (CfgW'(reading) >= off_th) : (CfgW'(reading) > on_th);
      if (t != st.active) begin
         r.hit       = 1'b1;
         r.code      = t ? dev : uev;
         r.st.since  = t ? now : '0;
         r.st.active = t;
      end else if (t && (st.since != '0) && (elapsed > TimeW'(max_hold))) begin
         // held too long: forced release
         r.hit       = 1'b1;
         r.code      = uev;
         r.st.active = 1'b0;
         r.st.since  = '0;
      end
      return r;
   endfunction

   // configuration
   logic [CfgW-1:0]  tl_on_ff, tl_off_ff, tr_on_ff, tr_off_ff;
   logic [LongW-1:0] long_ms_ff, max_hold_ff;
   logic [SpdW-1:0]  spd_ff;

   // latched tick
   logic [TimeW-1:0]         now_ff;
   logic [CountW-1:0]        count_ff;
   logic                     enc_dn_ff, aux_dn_ff, pl_ff, pr_ff;
   logic [TouchBits-1:0]     tl_rd_ff, tr_rd_ff;

   // block state
   logic [CountW-1:0]        base_ff;
   btn_st_type               enc_st_ff, aux_st_ff;
   logic                     pl_prev_ff, pr_prev_ff;
   tch_st_type               tl_st_ff, tr_st_ff;

   // per-tick work
   logic signed [CountW-1:0] diff_ff, diff_in;
   logic [DetCntW-1:0]       n_ff;
   logic [NumOther-1:0]      mask_ff, mask_in;
   ev_code_type              codes_ff [NumOther];
   ev_code_type              codes_in [NumOther];

   // output register
   logic                     rsp_valid_ff;
   ev_code_type              rsp_code_ff;
   logic                     rsp_last_ff;

   btn_res_type              enc_r, aux_r;
   tch_res_type              tl_r, tr_r;

   logic [SpdW-1:0]          spd;
   logic signed [CountW-1:0] spd_s, nspd_s;
   logic                     go_cw, go_ccw, room, room_nx, more, detent_pending, detent_last;
   logic [NumOther-1:0]      pick, mask_rest;
   ev_code_type              other_code;
   logic                     rsp_free;

   // ---------------- other sources, evaluated once per tick ----------------
   always_comb begin
      enc_r = btn_eval(enc_dn_ff, enc_st_ff, now_ff, long_ms_ff, EvEncShort, EvEncLong);
      aux_r = btn_eval(aux_dn_ff, aux_st_ff, now_ff, long_ms_ff, EvAuxShort, EvAuxLong);
      tl_r  = touch_eval(tl_rd_ff, tl_on_ff, tl_off_ff, tl_st_ff, now_ff, max_hold_ff,
                         EvTlDown, EvTlUp);
      tr_r  = touch_eval(tr_rd_ff, tr_on_ff, tr_off_ff, tr_st_ff, now_ff, max_hold_ff,
                         EvTrDown, EvTrUp);
      mask_in     = {tr_r.hit, tl_r.hit, (pr_ff != pr_prev_ff), (pl_ff != pl_prev_ff),
                     aux_r.hit, enc_r.hit};
      codes_in[0] = enc_r.code;
      codes_in[1] = aux_r.code;
      codes_in[2] = pl_ff ? EvDitDown : EvDitUp;
      codes_in[3] = pr_ff ? EvDahDown : EvDahUp;
      codes_in[4] = tl_r.code;
      codes_in[5] = tr_r.code;
   end

   // ---------------- detent stepping ----------------
   always_comb begin
      spd     = (spd_ff == '0) ? SpdW'(1) : spd_ff;
      spd_s   = signed'(CountW'(spd));
      nspd_s  = -spd_s;
      go_cw   = (diff_ff >= spd_s);
      go_ccw  = (diff_ff <= nspd_s);
      room    = (n_ff < DetCntW'(MaxDetents));
      room_nx = (n_ff < DetCntW'(MaxDetents - 1));
      diff_in = go_cw ? (diff_ff - spd_s) : (diff_ff + spd_s);
      more    = ((diff_in >= spd_s) || (diff_in <= nspd_s)) && room_nx;
      detent_pending = (go_cw || go_ccw) && room;
      detent_last    = !more && (mask_ff == '0);
   end

   // ---------------- other event pick, lowest source first ----------------
   always_comb begin
      pick       = mask_ff & (~mask_ff + NumOther'(1));
      mask_rest  = mask_ff & ~pick;
      other_code = EvEncShort;
      for (int i = 0; i < NumOther; i++) begin
         if (pick[i]) begin
            other_code = codes_ff[i];
         end
      end
   end

   assign rsp_free           = !rsp_valid_ff || !rsp_stall;
   assign sts.detent_pending = detent_pending;
   assign sts.other_pending  = (mask_ff != '0);
   assign sts.rsp_free       = rsp_free;

   // ---------------- control state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         tl_on_ff     <= '1;
         tl_off_ff    <= '1;
         tr_on_ff     <= '1;
         tr_off_ff    <= '1;
         long_ms_ff   <= LongW'(800);
         spd_ff       <= SpdW'(2);
         max_hold_ff  <= LongW'(3000);
         base_ff      <= '0;
         enc_st_ff    <= '0;
         aux_st_ff    <= '0;
         pl_prev_ff   <= 1'b0;
         pr_prev_ff   <= 1'b0;
         tl_st_ff     <= '0;
         tr_st_ff     <= '0;
         n_ff         <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_idx_type'(csr_index))
               CsrTlOn:    tl_on_ff    <= csr_write_data;
               CsrTlOff:   tl_off_ff   <= csr_write_data;
               CsrTrOn:    tr_on_ff    <= csr_write_data;
               CsrTrOff:   tr_off_ff   <= csr_write_data;
               CsrLongMs:  long_ms_ff  <= csr_write_data[LongW-1:0];
               CsrSpd:     spd_ff      <= csr_write_data[SpdW-1:0];
               CsrMaxHold: max_hold_ff <= csr_write_data[LongW-1:0];
               default: ;
            endcase
         end

         if (cmd.eval) begin
            enc_st_ff  <= enc_r.st;
            aux_st_ff  <= aux_r.st;
            pl_prev_ff <= pl_ff;
            pr_prev_ff <= pr_ff;
            tl_st_ff   <= tl_r.st;
            tr_st_ff   <= tr_r.st;
            n_ff       <= '0;
            mask_ff    <= mask_in;
         end

         if (cmd.emit_detent) begin
            base_ff <= go_cw ? (base_ff + CountW'(spd)) : (base_ff - CountW'(spd));
            n_ff    <= n_ff + DetCntW'(1);
         end

         if (cmd.emit_other) begin
            mask_ff <= mask_rest;
         end

         if (cmd.emit_detent || cmd.emit_other) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- payload ----------------
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff    <= req_now_ms;
         count_ff  <= req_encoder_count;
         enc_dn_ff <= req_encoder_button_down;
         aux_dn_ff <= req_aux_button_down;
         pl_ff     <= req_paddle_left_down;
         pr_ff     <= req_paddle_right_down;
         tl_rd_ff  <= req_touch_left_reading;
         tr_rd_ff  <= req_touch_right_reading;
      end
      if (cmd.eval) begin
         diff_ff <= signed'(count_ff - base_ff);
         for (int i = 0; i < NumOther; i++) begin
            codes_ff[i] <= codes_in[i];
         end
      end
      if (cmd.emit_detent) begin
         diff_ff <= diff_in;
      end
      if (cmd.emit_detent) begin
         rsp_code_ff <= go_cw ? EvCw : EvCcw;
         rsp_last_ff <= detent_last;
      end else if (cmd.emit_other) begin
         rsp_code_ff <= other_code;
         rsp_last_ff <= (mask_rest == '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_code   = rsp_code_ff;
   assign rsp_last_of_tick = rsp_last_ff;

`ifndef SYNTHESIS
   a_detent_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= DetCntW'(MaxDetents))
      else $error("detent count past limit");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.eval, cmd.emit_detent, cmd.emit_other}))
      else $error("more than one datapath command");

   a_detent_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_detent |-> (detent_pending && rsp_free))
      else $error("detent emitted without room or pending step");

   a_other_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_other |=> (mask_ff == ($past(mask_ff) & ~$past(pick))) && rsp_valid_ff)
      else $error("event mask not retired correctly");
`endif

endmodule

>>> hw/rtl/key_input_event_scanner.sv
// Channel   Dir  Handshake          Payload
// req_      in   req_valid/stall    now_ms, encoder_count, buttons, paddles, touch readings
// rsp_      out  rsp_valid/stall    event_code, last_of_tick
// csr_      in   csr_write_enable   csr_index, csr_write_data
//
// A tick goes through load, evaluate, the detent emit phase and the other-event emit phase
// before the next transfer is taken; each event enters the single output register, and
// an output stall holds the emit phases.
// Synchronous reset restores register defaults, clears state and holds req_stall high.
// req_stall is high from a transfer until the controller is idle again, after the tick's
// last event has entered the output register.
module key_input_event_scanner (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [kies_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [kies_pkg::CfgW-1:0]           csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [kies_pkg::TimeW-1:0]          req_now_ms,
   input  logic signed [kies_pkg::CountW-1:0]  req_encoder_count,
   input  logic                                req_encoder_button_down,
   input  logic                                req_aux_button_down,
   input  logic                                req_paddle_left_down,
   input  logic                                req_paddle_right_down,
   input  logic [kies_pkg::TouchBits-1:0]      req_touch_left_reading,
   input  logic [kies_pkg::TouchBits-1:0]      req_touch_right_reading,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [3:0]                          rsp_event_code,
   output logic                                rsp_last_of_tick
);
   import kies_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   kies_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kies_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .sts                     (sts),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data),
      .req_now_ms              (req_now_ms),
      .req_encoder_count       (req_encoder_count),
      .req_encoder_button_down (req_encoder_button_down),
      .req_aux_button_down     (req_aux_button_down),
      .req_paddle_left_down    (req_paddle_left_down),
      .req_paddle_right_down   (req_paddle_right_down),
      .req_touch_left_reading  (req_touch_left_reading),
      .req_touch_right_reading (req_touch_right_reading),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_event_code          (rsp_event_code),
      .rsp_last_of_tick        (rsp_last_of_tick)
   );

endmodule
